// File: src/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg
// shared types, register indexes and reset values of the flight phase detector
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SATELLITES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_HOLD   = 3'd4;

    localparam logic [4:0]  RST_MIN_SATELLITES = 5'd4;
    localparam logic [15:0] RST_TAKEOFF_SPEED  = 16'd400;
    localparam logic [15:0] RST_LANDING_SPEED  = 16'd120;
    localparam logic [15:0] RST_TAKEOFF_HOLD   = 16'd2000;
    localparam logic [15:0] RST_LANDING_HOLD   = 16'd5000;

    typedef enum logic [2:0] {
        PH_PRE     = 3'd0,
        PH_TAKEOFF = 3'd1,
        PH_FLIGHT  = 3'd2,
        PH_LANDING = 3'd3,
        PH_POST    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [4:0]  min_satellites;
        logic [15:0] takeoff_speed;
        logic [15:0] landing_speed;
        logic [15:0] takeoff_hold;
        logic [15:0] landing_hold;
    } t_cfg;

    typedef struct packed {
        logic        manual;
        logic        takeoff_ok;
        logic        landing_ok;
        logic [31:0] now_ms;
    } t_item;

endpackage

// File: src/fpd_front.sv
// ----------------------------------------------------------------------------
// fpd_front
// accepts input beats and classifies each sample against the thresholds
// ----------------------------------------------------------------------------
module fpd_front
    import fpd_pkg::*;
(
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_now_ms,
    input  logic        i_gps_fix,
    input  logic [4:0]  i_satellites,
    input  logic [15:0] i_ground_speed,
    input  t_cfg        i_cfg,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_item       o_item
);

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    always_comb begin
        o_item.manual     = i_mode;
        o_item.takeoff_ok = i_gps_fix && (i_satellites >= i_cfg.min_satellites)
                            && (i_ground_speed > i_cfg.takeoff_speed);
        o_item.landing_ok = i_gps_fix && (i_ground_speed < i_cfg.landing_speed);
        o_item.now_ms     = i_now_ms;
    end

endmodule

// File: src/fpd_queue.sv
// ----------------------------------------------------------------------------
// fpd_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module fpd_queue
    import fpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: src/fpd_back.sv
// ----------------------------------------------------------------------------
// fpd_back
// phase state machine with hold timers and the result register
// ----------------------------------------------------------------------------
module fpd_back
    import fpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_flight_phase
);

    t_phase      r_phase, n_phase;
    logic        r_tk_pend, n_tk_pend;
    logic [31:0] r_tk_start, n_tk_start;
    logic        r_ld_pend, n_ld_pend;
    logic [31:0] r_ld_start, n_ld_start;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_phase, n_out_phase;
    logic [31:0] tk_elapsed;
    logic [31:0] ld_elapsed;

    assign o_pop          = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid    = r_out_valid;
    assign o_flight_phase = r_out_phase;
    assign tk_elapsed     = i_item.now_ms - r_tk_start;
    assign ld_elapsed     = i_item.now_ms - r_ld_start;

    always_comb begin
        n_phase     = r_phase;
        n_tk_pend   = r_tk_pend;
        n_tk_start  = r_tk_start;
        n_ld_pend   = r_ld_pend;
        n_ld_start  = r_ld_start;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_phase = r_out_phase;
        if (o_pop) begin
            if (i_item.manual) begin
                if (r_phase == PH_PRE) begin
                    n_phase   = PH_TAKEOFF;
                    n_tk_pend = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    PH_TAKEOFF: n_phase = PH_FLIGHT;
                    PH_LANDING: n_phase = PH_POST;
                    PH_FLIGHT: begin
                        if (i_item.landing_ok) begin
                            if (!r_ld_pend) begin
                                n_ld_pend  = 1'b1;
                                n_ld_start = i_item.now_ms;
                            end else if (ld_elapsed >= {16'd0, i_cfg.landing_hold}) begin
                                n_phase   = PH_LANDING;
                                n_ld_pend = 1'b0;
                            end
                        end else begin
                            n_ld_pend = 1'b0;
                        end
                    end
                    default: begin
                        if (i_item.takeoff_ok) begin
                            if (!r_tk_pend) begin
                                n_tk_pend  = 1'b1;
                                n_tk_start = i_item.now_ms;
                            end else if (tk_elapsed >= {16'd0, i_cfg.takeoff_hold}) begin
                                n_phase   = PH_TAKEOFF;
                                n_tk_pend = 1'b0;
                            end
                        end else begin
                            n_tk_pend = 1'b0;
                        end
                    end
                endcase
            end
            n_out_valid = 1'b1;
            n_out_phase = n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PRE;
            r_tk_pend   <= 1'b0;
            r_tk_start  <= '0;
            r_ld_pend   <= 1'b0;
            r_ld_start  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tk_pend   <= n_tk_pend;
            r_tk_start  <= n_tk_start;
            r_ld_pend   <= n_ld_pend;
            r_ld_start  <= n_ld_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_phase <= n_out_phase;
    end

endmodule

// File: src/flight_phase_detector_top.sv
// ----------------------------------------------------------------------------
// flight_phase_detector_top
// five-phase flight detector: front classifies, queue decouples, back decides
// ----------------------------------------------------------------------------
// a taken input beat passes through the queue and then the result register
// throughput: one item per cycle while the result side does not stall, set by the back stage
// the queue absorbs QUEUE_DEPTH items while the result side stalls
// reset: synchronous, clears phase, pending flags, queue and result valid,
// and loads the default thresholds and hold times
// ----------------------------------------------------------------------------
module flight_phase_detector_top
    import fpd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_gps_fix,
    input  logic [4:0]            i_satellites,
    input  logic [15:0]           i_ground_speed,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_flight_phase
);

    t_cfg  r_cfg, n_cfg;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item front_item;
    t_item queue_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_SATELLITES: n_cfg.min_satellites = i_cfg_data[4:0];
                CFG_TAKEOFF_SPEED:  n_cfg.takeoff_speed  = i_cfg_data;
                CFG_LANDING_SPEED:  n_cfg.landing_speed  = i_cfg_data;
                CFG_TAKEOFF_HOLD:   n_cfg.takeoff_hold   = i_cfg_data;
                CFG_LANDING_HOLD:   n_cfg.landing_hold   = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_satellites <= RST_MIN_SATELLITES;
            r_cfg.takeoff_speed  <= RST_TAKEOFF_SPEED;
            r_cfg.landing_speed  <= RST_LANDING_SPEED;
            r_cfg.takeoff_hold   <= RST_TAKEOFF_HOLD;
            r_cfg.landing_hold   <= RST_LANDING_HOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fpd_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_now_ms       (i_now_ms),
        .i_gps_fix      (i_gps_fix),
        .i_satellites   (i_satellites),
        .i_ground_speed (i_ground_speed),
        .i_cfg          (r_cfg),
        .i_queue_full   (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    fpd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    fpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_flight_phase (o_flight_phase)
    );

endmodule

// File: verif/flight_phase_detector_top_tb.sv
// ----------------------------------------------------------------------------
// flight_phase_detector_top_tb
// self-checking bench: a directed walk through every phase and edge case, then
// randomized flights with noise under several threshold settings; a local
// phase predictor checks every result beat while both sides idle at random
// and the result side holds off long enough to back up the input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flight_phase_detector_top_tb
    import fpd_pkg::*;
;

    localparam int          CLK_HALF    = 5;
    localparam int          N_SETTINGS  = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic        MODE_GPS    = 1'b0;
    localparam logic        MODE_MANUAL = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic        fix;
        logic [4:0]  sats;
        logic [15:0] speed;
    } t_gps_beat;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode         = 1'b0;
    logic [31:0]           i_now_ms       = '0;
    logic                  i_gps_fix      = 1'b0;
    logic [4:0]            i_satellites   = '0;
    logic [15:0]           i_ground_speed = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [2:0]            o_flight_phase;

    // threshold shadow
    logic [4:0]  cfg_min_sats = RST_MIN_SATELLITES;
    logic [15:0] cfg_to_speed = RST_TAKEOFF_SPEED;
    logic [15:0] cfg_ld_speed = RST_LANDING_SPEED;
    logic [15:0] cfg_to_hold  = RST_TAKEOFF_HOLD;
    logic [15:0] cfg_ld_hold  = RST_LANDING_HOLD;

    // predicted detector state
    t_phase      fp_phase = PH_PRE;
    logic        to_armed = 1'b0;
    logic [31:0] to_t0    = '0;
    logic        ld_armed = 1'b0;
    logic [31:0] ld_t0    = '0;

    t_gps_beat   beats_to_send[$];
    t_phase      phases_due[$];
    logic [31:0] clock_ms     = '0;
    int          items_queued = 0;
    int          err_count    = 0;
    int unsigned src_wait     = 0;
    int unsigned snk_wait     = 0;
    bit          src_quiet    = 1'b0;
    bit          snk_quiet    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned beats_seen   = 0;
    int unsigned next_hold_at = 150;
    int unsigned cycle_count  = 0;

    flight_phase_detector_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_now_ms       (i_now_ms),
        .i_gps_fix      (i_gps_fix),
        .i_satellites   (i_satellites),
        .i_ground_speed (i_ground_speed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_flight_phase (o_flight_phase)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        err_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    function automatic int unsigned draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic advance_phase(input t_gps_beat b);
        logic [31:0] since;
        if (b.mode == MODE_MANUAL) begin
            if (fp_phase == PH_PRE) begin
                fp_phase = PH_TAKEOFF;
                to_armed = 1'b0;
            end
        end else begin
            case (fp_phase)
                PH_TAKEOFF: fp_phase = PH_FLIGHT;
                PH_LANDING: fp_phase = PH_POST;
                PH_FLIGHT: begin
                    since = b.now_ms - ld_t0;
                    if (b.fix && b.speed < cfg_ld_speed) begin
                        if (!ld_armed) begin
                            ld_armed = 1'b1;
                            ld_t0    = b.now_ms;
                        end else if (since >= 32'(cfg_ld_hold)) begin
                            fp_phase = PH_LANDING;
                            ld_armed = 1'b0;
                        end
                    end else begin
                        ld_armed = 1'b0;
                    end
                end
                default: begin
                    since = b.now_ms - to_t0;
                    if (b.fix && b.sats >= cfg_min_sats && b.speed > cfg_to_speed) begin
                        if (!to_armed) begin
                            to_armed = 1'b1;
                            to_t0    = b.now_ms;
                        end else if (since >= 32'(cfg_to_hold)) begin
                            fp_phase = PH_TAKEOFF;
                            to_armed = 1'b0;
                        end
                    end else begin
                        to_armed = 1'b0;
                    end
                end
            endcase
        end
        phases_due.push_back(fp_phase);
    endtask

    task automatic check_phase(input logic [2:0] got);
        t_phase want;
        if (phases_due.size() == 0) begin
            flag_error($sformatf("phase %0d with nothing outstanding", got));
            return;
        end
        want = phases_due.pop_front();
        if (got !== want) begin
            flag_error($sformatf("phase %0d, want %0d (%s)", got, want, want.name()));
        end
    endtask

    // input side
    always @(posedge i_clk) begin : drive_in
        t_gps_beat b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_phase({i_mode, i_now_ms, i_gps_fix, i_satellites, i_ground_speed});
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (src_wait != 0) begin
                    src_wait--;
                    i_in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    b = beats_to_send.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= b.mode;
                    i_now_ms       <= b.now_ms;
                    i_gps_fix      <= b.fix;
                    i_satellites   <= b.sats;
                    i_ground_speed <= b.speed;
                    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
                    src_wait = draw_gap(src_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long result hold-offs, paced by accepted input beats
    always @(posedge i_clk) begin : rx_hold
        if (!i_rst_n) begin
            hold_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) beats_seen <= beats_seen + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (beats_seen >= next_hold_at) begin
                hold_left    <= $urandom_range(60, 250);
                next_hold_at <= next_hold_at + $urandom_range(250, 450);
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : watch_out
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_phase(o_flight_phase);
                if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
                snk_wait = draw_gap(snk_quiet);
            end else if (snk_wait != 0) begin
                snk_wait--;
            end
            i_out_stall <= (hold_left != 0) || (snk_wait != 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_beat(input logic mode, input logic [31:0] now, input logic fix,
                             input logic [4:0] sats, input logic [15:0] speed);
        beats_to_send.push_back({mode, now, fix, sats, speed});
        items_queued++;
    endtask

    task automatic push_gps(input logic fix, input logic [4:0] sats, input logic [15:0] speed,
                            input int unsigned step);
        clock_ms = clock_ms + step;
        push_beat(MODE_GPS, clock_ms, fix, sats, speed);
    endtask

    task automatic push_manual();
        push_beat(MODE_MANUAL, $urandom(), 1'($urandom()), 5'($urandom()), 16'($urandom()));
    endtask

    function automatic logic [4:0] enough_sats();
        return 5'($urandom_range(int'(cfg_min_sats), 31));
    endfunction

    function automatic logic [15:0] fast_speed();
        if (cfg_to_speed == 16'hFFFF) return 16'($urandom());
        if ($urandom_range(0, 3) == 0) return cfg_to_speed + 16'd1;
        return 16'($urandom_range(int'(cfg_to_speed) + 1, 65535));
    endfunction

    function automatic logic [15:0] slow_speed();
        if (cfg_ld_speed == 16'd0) return 16'($urandom());
        if ($urandom_range(0, 3) == 0) return cfg_ld_speed - 16'd1;
        return 16'($urandom_range(0, int'(cfg_ld_speed) - 1));
    endfunction

    function automatic int unsigned hold_step(input logic [15:0] hold, input int n);
        int unsigned jitter;
        jitter = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 200);
        return int'(hold) / (n - 1) + jitter;
    endfunction

    task automatic push_noise();
        if ($urandom_range(0, 3) == 0) begin
            push_manual();
        end else begin
            if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
            push_gps(1'($urandom()), 5'($urandom()), 16'($urandom()), $urandom_range(0, 3000));
        end
    endtask

    // ground roll, climb-out, cruise, approach, rollout
    task automatic queue_flight();
        int          n;
        int          i;
        int unsigned step;
        if ($urandom_range(0, 5) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 30000);
        repeat ($urandom_range(0, 2)) begin
            push_gps(1'b1, 5'($urandom()), 16'($urandom_range(0, int'(cfg_to_speed))),
                     $urandom_range(0, 1000));
        end
        if ($urandom_range(0, 7) == 0) push_manual();
        n    = $urandom_range(2, 6);
        step = hold_step(cfg_to_hold, n);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) != 0) begin
                push_gps(1'b1, enough_sats(), fast_speed(), (i == 0) ? 1 : step);
            end else if (cfg_min_sats != 0 && $urandom_range(0, 1) == 0) begin
                push_gps(1'b1, 5'($urandom_range(0, int'(cfg_min_sats) - 1)), fast_speed(), step);
            end else if ($urandom_range(0, 1) == 0) begin
                push_gps(1'b0, enough_sats(), fast_speed(), step);
            end else begin
                push_gps(1'b1, enough_sats(), 16'($urandom_range(0, int'(cfg_to_speed))), step);
            end
        end
        push_gps(1'($urandom()), 5'($urandom()), 16'($urandom()), $urandom_range(0, 500));
        repeat ($urandom_range(0, 4)) begin
            push_gps(1'($urandom()), 5'($urandom()),
                     16'($urandom_range(int'(cfg_ld_speed), 65535)), $urandom_range(0, 2000));
        end
        n    = $urandom_range(2, 6);
        step = hold_step(cfg_ld_hold, n);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) != 0) begin
                push_gps(1'b1, 5'($urandom()), slow_speed(), (i == 0) ? 1 : step);
            end else if ($urandom_range(0, 1) == 0) begin
                push_gps(1'b0, 5'($urandom()), slow_speed(), step);
            end else begin
                push_gps(1'b1, 5'($urandom()),
                         16'($urandom_range(int'(cfg_ld_speed), 65535)), step);
            end
        end
        push_gps(1'($urandom()), 5'($urandom()), 16'($urandom()), $urandom_range(0, 500));
        repeat ($urandom_range(0, 2)) begin
            push_gps(1'($urandom()), 5'($urandom()), slow_speed(), $urandom_range(0, 1000));
        end
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (beats_to_send.size() != 0 || i_in_valid || phases_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MIN_SATELLITES: cfg_min_sats = data[4:0];
            CFG_TAKEOFF_SPEED:  cfg_to_speed = data;
            CFG_LANDING_SPEED:  cfg_ld_speed = data;
            CFG_TAKEOFF_HOLD:   cfg_to_hold  = data;
            CFG_LANDING_HOLD:   cfg_ld_hold  = data;
            default: ;
        endcase
    endtask

    task automatic load_setting(input int k);
        logic [4:0]  sats;
        logic [15:0] to_spd;
        logic [15:0] ld_spd;
        logic [15:0] to_hld;
        logic [15:0] ld_hld;
        sats   = 5'($urandom());
        to_spd = 16'($urandom_range(0, 3000));
        ld_spd = 16'($urandom_range(0, 600));
        to_hld = 16'($urandom_range(0, 8000));
        ld_hld = 16'($urandom_range(0, 8000));
        case (k)
            1: begin
                sats   = 5'd0;
                to_spd = 16'd0;
                ld_spd = 16'hFFFF;
                to_hld = 16'd0;
                ld_hld = 16'd0;
            end
            2: begin
                sats   = 5'd31;
                to_spd = 16'hFFFF;
                ld_spd = 16'd0;
                to_hld = 16'hFFFF;
                ld_hld = 16'hFFFF;
            end
            3: begin
                to_hld = 16'hFFFF;
                ld_hld = 16'hFFFF;
            end
            default: ;
        endcase
        // indexes past the register file change nothing
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_LANDING_HOLD) + 1, (1 << CFG_IDX_W) - 1)),
                  16'($urandom()));
        write_reg(CFG_MIN_SATELLITES, {11'($urandom()), sats});
        write_reg(CFG_TAKEOFF_SPEED, to_spd);
        write_reg(CFG_LANDING_SPEED, ld_spd);
        write_reg(CFG_TAKEOFF_HOLD, to_hld);
        write_reg(CFG_LANDING_HOLD, ld_hld);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int k;
        int target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk at reset thresholds
        push_beat(MODE_GPS, 32'h0000_0000, 1'b0, 5'd31, 16'hFFFF);  // no fix
        push_beat(MODE_GPS, 32'hFFFF_FFFF, 1'b1, 5'd3, 16'd1000);   // too few satellites
        push_beat(MODE_GPS, 32'd50, 1'b1, 5'd4, 16'd400);           // speed at threshold
        push_beat(MODE_GPS, 32'd100, 1'b1, 5'd4, 16'd401);          // arms takeoff
        push_beat(MODE_GPS, 32'd2099, 1'b1, 5'd31, 16'hFFFF);       // one ms short
        push_beat(MODE_GPS, 32'd2100, 1'b0, 5'd31, 16'hFFFF);       // fix lost, disarm
        push_beat(MODE_GPS, 32'd2200, 1'b1, 5'd5, 16'd900);         // re-arm
        push_manual();                                              // manual from preflight
        push_manual();                                              // not a sample
        push_beat(MODE_GPS, 32'd2300, 1'b0, 5'd0, 16'd0);           // into flight
        push_manual();                                              // ignored in flight
        push_beat(MODE_GPS, 32'hFFFF_F000, 1'b1, 5'd0, 16'd119);    // arms landing
        push_beat(MODE_GPS, 32'hFFFF_F100, 1'b1, 5'd0, 16'd120);    // speed at threshold
        push_beat(MODE_GPS, 32'hFFFF_FF00, 1'b1, 5'd2, 16'd0);      // re-arm landing
        push_beat(MODE_GPS, 32'h0000_1287, 1'b1, 5'd2, 16'd0);      // one ms short across wrap
        push_beat(MODE_GPS, 32'h0000_1288, 1'b1, 5'd2, 16'd0);      // landing detected
        push_manual();                                              // ignored in landing
        push_beat(MODE_GPS, 32'd0, 1'b0, 5'd0, 16'd0);              // into post-flight
        push_manual();                                              // ignored in post-flight
        push_beat(MODE_GPS, 32'd10, 1'b1, 5'd4, 16'd500);           // arms from post-flight
        push_beat(MODE_GPS, 32'd5, 1'b1, 5'd4, 16'd500);            // timestamp runs backwards
        push_beat(MODE_GPS, 32'd6, 1'b1, 5'd4, 16'd500);            // into flight
        clock_ms = 32'd6;

        for (k = 0; k < N_SETTINGS; k++) begin
            if (k != 0) begin
                wait_drain();
                load_setting(k);
            end
            target = items_queued + ((k == 2) ? 100 : 250);
            while (items_queued < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) push_noise();
                end else begin
                    queue_flight();
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
